// File: rtl/core/pic_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the priority interrupt controller.
// No dependencies; imported by pic_scan and priority_interrupt_controller_top.
package pic_pkg;

  // Fixed field geometry
  localparam int unsigned MAX_SOURCES = 8;
  localparam int unsigned SRC_W       = 3;
  localparam int unsigned PRIO_BITS   = 4;
  localparam int unsigned VEC_W       = 8;
  localparam int unsigned PRIO_WORD_W = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // Request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_RAISE    = 2'd0,
    REQ_CLEAR    = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_NOP      = 2'd3
  } req_type_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 3'd0,
    CFG_MASK    = 3'd1,
    CFG_PRIO    = 3'd2,
    CFG_HANDLER = 3'd3
  } cfg_reg_e;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_e;

  // Outcome of one priority scan
  typedef struct packed {
    logic             hit;
    logic [SRC_W-1:0] chosen;
  } scan_res_t;

endpackage

// File: rtl/core/pic_scan.sv
`timescale 1ns / 1ps
// Iterative priority scanner: walks the sources one per cycle with a single
// 4-bit compare and keeps the best candidate. Depends on pic_pkg.
module pic_scan #(
  parameter int unsigned SOURCE_COUNT = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [pic_pkg::VEC_W-1:0]          active_i,
  input  logic [pic_pkg::PRIO_WORD_W-1:0]    prio_word_i,
  input  logic [pic_pkg::VEC_W-1:0]          handler_i,
  output logic                               done_o,
  output pic_pkg::scan_res_t                 res_o
);
  import pic_pkg::*;

  localparam logic [SRC_W-1:0] LastIdx = SRC_W'(SOURCE_COUNT - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [SRC_W-1:0]     idx_q, idx_d;
  logic                 found_q, found_d;
  logic [SRC_W-1:0]     best_q, best_d;
  logic [PRIO_BITS-1:0] best_prio_q, best_prio_d;
  logic [PRIO_BITS-1:0] cur_prio;
  logic                 take;
  logic                 last;
  scan_res_t            res_q, res_d;

  // Priority field of the source under the cursor
  assign cur_prio = prio_word_i[idx_q*PRIO_BITS +: PRIO_BITS];
  // Later index wins on equal priority, hence >=
  assign take = active_i[idx_q] && (!found_q || (cur_prio >= best_prio_q));
  assign last = busy_q && (idx_q == LastIdx);

  // Step logic
  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    done_d      = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      found_d = 1'b0;
    end else if (busy_q) begin
      if (take) begin
        found_d     = 1'b1;
        best_d      = idx_q;
        best_prio_d = cur_prio;
      end
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        idx_d = idx_q + SRC_W'(1);
      end
    end
  end

  // Handler check on the final pick
  always_comb begin
    res_d        = res_q;
    if (last) begin
      res_d.hit    = found_d && handler_i[best_d];
      res_d.chosen = res_d.hit ? best_d : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  // Candidate and result registers
  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    res_q       <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/core/priority_interrupt_controller_top.sv
`timescale 1ns / 1ps
// Top level of the priority interrupt controller: pending bits, config
// registers, request sequencer and output register. Uses pic_pkg, pic_scan.
//
// Usage:
//  - Request channel (in_valid_i / in_stall_o) carries req_type and
//    source_index; a beat is taken when valid is high and stall is low.
//  - Result channel (out_valid_o / out_stall_i) returns one beat per request:
//    dispatched, chosen_source and the pending bits after the request.
//  - Config channel (cfg_valid_i / cfg_ready_o) writes enable, mask, priority
//    and handler registers; always ready. Unknown indexes are dropped.
//  - Raise, clear and no-op requests skip the scanner and go straight to the
//    emit state; the next request is taken once the sequencer is idle again.
//  - Dispatch: one source is compared per cycle in the shared scanner, so the
//    result is ready only after the scanner has walked all SOURCE_COUNT
//    sources, and no new request is taken while the scan runs.
//  - One request in flight at a time; the next is accepted once the result
//    has moved into the output register, even if that beat still waits.
//  - If the receiver stalls, the output register holds its beat and the next
//    finished result waits in the sequencer; requests stall behind it.
//  - Reset clears pending bits and all config registers; no sweep is needed.
module priority_interrupt_controller_top #(
  parameter int unsigned SOURCE_COUNT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [7:0]                        source_index_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              dispatched_o,
  output logic [2:0]                        chosen_source_o,
  output logic [7:0]                        pending_now_o,
  // config channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pic_pkg::PRIO_WORD_W-1:0]   cfg_data_i
);
  import pic_pkg::*;

  localparam logic [7:0] SrcLimit = 8'(SOURCE_COUNT);

  ctrl_state_e          state_q, state_d;
  logic [VEC_W-1:0]     pending_q, pending_d;
  logic [VEC_W-1:0]     enable_q;
  logic [VEC_W-1:0]     mask_q;
  logic [PRIO_WORD_W-1:0] prio_q;
  logic [VEC_W-1:0]     handler_q;
  scan_res_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q;
  logic [SRC_W-1:0]     out_chosen_q;
  logic [VEC_W-1:0]     out_pending_q;
  logic                 in_take;
  logic                 out_free;
  logic                 out_load;
  logic                 scan_start;
  logic                 scan_done;
  scan_res_t            scan_res;
  logic [VEC_W-1:0]     active;
  logic                 src_ok;
  req_type_e            req;

  assign req      = req_type_e'(req_type_i);
  assign src_ok   = source_index_i < SrcLimit;
  assign out_free = !out_valid_q || !out_stall_i;
  assign active   = pending_q & enable_q & ~mask_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (req == REQ_DISPATCH) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    scan_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        scan_start = in_valid_i && (req == REQ_DISPATCH);
      end
      ST_SCAN: ;
      ST_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  assign in_take = in_valid_i && !in_stall_o;

  // Pending update on raise and clear
  always_comb begin
    pending_d = pending_q;
    if (in_take && src_ok) begin
      if (req == REQ_RAISE) begin
        pending_d[source_index_i[SRC_W-1:0]] = 1'b1;
      end else if (req == REQ_CLEAR) begin
        pending_d[source_index_i[SRC_W-1:0]] = 1'b0;
      end
    end
  end

  // Held result of the current request
  always_comb begin
    res_d = res_q;
    if (in_take) begin
      res_d = '0;
    end else if (scan_done) begin
      res_d = scan_res;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  pic_scan #(
    .SOURCE_COUNT(SOURCE_COUNT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .active_i   (active),
    .prio_word_i(prio_q),
    .handler_i  (handler_q),
    .done_o     (scan_done),
    .res_o      (scan_res)
  );

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      mask_q    <= '0;
      prio_q    <= '0;
      handler_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ENABLE:  enable_q  <= cfg_data_i[VEC_W-1:0];
        CFG_MASK:    mask_q    <= cfg_data_i[VEC_W-1:0];
        CFG_PRIO:    prio_q    <= cfg_data_i;
        CFG_HANDLER: handler_q <= cfg_data_i[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_hit_q     <= res_q.hit;
      out_chosen_q  <= res_q.chosen;
      out_pending_q <= pending_q;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign dispatched_o    = out_hit_q;
  assign chosen_source_o = out_chosen_q;
  assign pending_now_o   = out_pending_q;

endmodule
